[src/bcomp_pkg.sv]
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types and constants for the compensation block.
// ----------------------------------------------------------------------------
`default_nettype none
package bcomp_pkg;

   localparam int unsigned DataWidth = 32;

   // Configuration register indexes.
   localparam logic [1:0] CsrOversampling = 2'd0;
   localparam logic [1:0] CsrCoeffA       = 2'd1;
   localparam logic [1:0] CsrCoeffB       = 2'd2;
   localparam logic [1:0] CsrCoeffC       = 2'd3;

   // Input word kinds.
   localparam logic CmdTemperature = 1'b0;
   localparam logic CmdPressure    = 1'b1;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_SDIV = 2'd1,
      OP_UDIV = 2'd2
   } alu_op_type;

   // Request to the shared unit.
   typedef struct packed {
      logic                 start;
      alu_op_type           op;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
   } alu_req_type;

   // Answer from the shared unit.
   typedef struct packed {
      logic                 done;
      logic [DataWidth-1:0] result;
   } alu_rsp_type;

   // Arithmetic shift right of a 32-bit word.
   function automatic logic [DataWidth-1:0] asr32(input logic [DataWidth-1:0] x,
                                                  input logic [4:0] n);
      asr32 = DataWidth'($signed(x) >>> n);
   endfunction

   // Sign extension of a 16-bit coefficient.
   function automatic logic [DataWidth-1:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage
`default_nettype wire

[src/barometer_compensation_top.sv]
// ----------------------------------------------------------------------------
// Barometer compensation top level
// Turns raw temperature and pressure ADC words into compensated values.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one word: command (0 temperature,
// 1 pressure) and the 24-bit ADC word. The rsp_ channel returns one word
// per request: kind, the signed value (0.1 degC or Pa) and a status bit set
// when a divisor was zero. Calibration and oversampling are written on the
// csr_ port while the block is idle.
// After a temperature word is accepted the chain runs one multiply, a
// division and a finishing state before rsp_valid rises, and ends before
// the division when its divisor is zero. A pressure word runs ten
// multiplies and the division, and ends before the division when B4 is
// zero. One word is processed at a time; req_stall is high while a word is
// in work or a result is waiting, and the next word is taken at the edge
// after the result is taken. The result holds in an output register while
// rsp_stall is high. Reset clears the stored compensation term and sets
// the oversampling to one and the coefficients to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module barometer_compensation_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [23:0] req_adc_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [31:0]      rsp_value,
   output logic             rsp_status,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import bcomp_pkg::*;

   logic [1:0]  oss_ff, oss_in;
   logic [63:0] ca_ff, ca_in, cb_ff, cb_in;
   logic [47:0] cc_ff, cc_in;
   logic        busy_ff, busy_in;
   logic        ov_ff, ov_in;
   logic        ok_ff, ok_in, os_ff, os_in;
   logic [31:0] ovl_ff, ovl_in;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   logic        finish, kind, status, accept;
   logic [31:0] value;

   // Configuration registers.
   always_comb begin
      oss_in = oss_ff; ca_in = ca_ff; cb_in = cb_ff; cc_in = cc_ff;
      if (csr_write) begin
         unique case (csr_index)
            CsrOversampling: oss_in = csr_data[1:0];
            CsrCoeffA:       ca_in  = csr_data;
            CsrCoeffB:       cb_in  = csr_data;
            CsrCoeffC:       cc_in  = csr_data[47:0];
            default:         oss_in = oss_ff;
         endcase
      end
   end

   assign req_stall = busy_ff || ov_ff;
   assign accept    = req_valid && !req_stall;

   // Busy flag and output word register.
   always_comb begin
      busy_in = busy_ff;
      ov_in   = ov_ff;
      ok_in = ok_ff; os_in = os_ff; ovl_in = ovl_ff;
      if (accept) busy_in = 1'b1;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      if (finish) begin
         busy_in = 1'b0;
         ov_in   = 1'b1;
         ok_in = kind; os_in = status; ovl_in = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= 2'd1;
         ca_ff   <= '0;
         cb_ff   <= '0;
         cc_ff   <= '0;
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         oss_ff  <= oss_in;
         ca_ff   <= ca_in;
         cb_ff   <= cb_in;
         cc_ff   <= cc_in;
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
      ok_ff  <= ok_in;
      os_ff  <= os_in;
      ovl_ff <= ovl_in;
   end

   bcomp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .command  (req_command),
      .adc_word (req_adc_word),
      .oss      (oss_ff),
      .coeff_a  (ca_ff),
      .coeff_b  (cb_ff),
      .coeff_c  (cc_ff),
      .alu_req  (alu_req),
      .alu_rsp  (alu_rsp),
      .finish   (finish),
      .kind     (kind),
      .value    (value),
      .status   (status)
   );

   bcomp_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign rsp_valid  = ov_ff;
   assign rsp_kind   = ok_ff;
   assign rsp_value  = ovl_ff;
   assign rsp_status = os_ff;

   // A zero-divisor result always carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_value == 32'd0))
      else $error("zero-divisor result with non-zero value");

   // No new word is taken while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while result pending");

   // Work finishes only while the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      finish |-> busy_ff)
      else $error("finish without work in progress");

endmodule
`default_nettype wire

[src/bcomp_alu.sv]
// ----------------------------------------------------------------------------
// Barometer compensation shared arithmetic unit
// A 32x32 wrapping multiply, and a restoring divider that
// produces one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
`default_nettype none
module bcomp_alu (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bcomp_pkg::alu_req_type req,
   output bcomp_pkg::alu_rsp_type      rsp
);
   import bcomp_pkg::*;

   logic                 busy_ff, busy_in;
   logic [5:0]           count_ff, count_in;
   logic [DataWidth-1:0] quot_ff, quot_in;
   logic [DataWidth-1:0] rem_ff, rem_in;
   logic [DataWidth-1:0] dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;
   logic [DataWidth-1:0] res_ff, res_in;
   logic [DataWidth:0]   trial;
   logic [DataWidth-1:0] rem_shift;
   logic [DataWidth-1:0] mag_a, mag_b;

   // Magnitudes for a signed division.
   always_comb begin
      mag_a = (req.op == OP_SDIV && req.a[DataWidth-1]) ? DataWidth'(-req.a) : req.a;
      mag_b = (req.op == OP_SDIV && req.b[DataWidth-1]) ? DataWidth'(-req.b) : req.b;
   end

   // One restoring step.
   always_comb begin
      rem_shift = {rem_ff[DataWidth-2:0], quot_ff[DataWidth-1]};
      trial     = {1'b0, rem_shift} - {1'b0, dvs_ff};
   end

   // Sequencing of the shared unit.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      if (busy_ff) begin
         // A set top remainder bit means the shifted remainder exceeds any divisor.
         if (rem_ff[DataWidth-1] || !trial[DataWidth]) begin
            rem_in = trial[DataWidth-1:0];
            quot_in = {quot_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quot_in = {quot_ff[DataWidth-2:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? DataWidth'(-quot_in) : quot_in;
         end
      end else if (req.start) begin
         unique case (req.op)
            OP_MUL: begin
               res_in  = DataWidth'(req.a * req.b);
               done_in = 1'b1;
            end
            OP_SDIV, OP_UDIV: begin
               busy_in  = 1'b1;
               count_in = 6'(DataWidth);
               quot_in  = mag_a;
               rem_in   = '0;
               dvs_in   = mag_b;
               neg_in   = (req.op == OP_SDIV) && (req.a[DataWidth-1] ^ req.b[DataWidth-1]);
            end
            default: begin
               res_in  = '0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule
`default_nettype wire

[src/bcomp_seq.sv]
// ----------------------------------------------------------------------------
// Barometer compensation sequencer
// Steps through the compensation chain, issuing each multiply and divide
// to the shared unit and doing the adds and shifts between them.
// ----------------------------------------------------------------------------
`default_nettype none
module bcomp_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   command,
   input  wire logic [23:0]            adc_word,
   input  wire logic [1:0]             oss,
   input  wire logic [63:0]            coeff_a,
   input  wire logic [63:0]            coeff_b,
   input  wire logic [47:0]            coeff_c,
   output bcomp_pkg::alu_req_type      alu_req,
   input  wire bcomp_pkg::alu_rsp_type alu_rsp,
   output logic                        finish,
   output logic                        kind,
   output logic [31:0]                 value,
   output logic                        status
);
   import bcomp_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_ISSUE = 8'b00000010,
      ST_WAIT  = 8'b00000100,
      ST_DONE  = 8'b00001000
   } state_type;

   state_type            state_ff, state_in;
   logic [4:0]           step_ff, step_in;
   logic                 cmd_ff, cmd_in;
   logic [23:0]          adc_ff, adc_in;
   logic [31:0]          term_ff, term_in;
   logic [31:0]          r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [31:0]          b6_ff, b6_in, b3_ff, b3_in, p_ff, p_in;
   logic                 stat_ff, stat_in;
   logic [31:0]          val_ff, val_in;
   alu_op_type           op;
   logic [31:0]          opa, opb, res, b3_pre, b3_sum, up, b7_diff, b4_t;
   logic                 last;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(coeff_a[63:48]);
   assign ac2 = sx16(coeff_a[47:32]);
   assign ac3 = sx16(coeff_a[31:16]);
   assign ac4 = {16'd0, coeff_a[15:0]};
   assign ac5 = {16'd0, coeff_b[63:48]};
   assign ac6 = {16'd0, coeff_b[47:32]};
   assign b1  = sx16(coeff_b[31:16]);
   assign b2  = sx16(coeff_b[15:0]);
   assign mc  = sx16(coeff_c[31:16]);
   assign md  = sx16(coeff_c[15:0]);

   assign res = alu_rsp.result;
   assign up  = 32'(adc_ff >> (4'd8 - {2'b00, oss}));

   // Steps of the chain: operands for the shared unit.
   // Temperature: 0 x1 mult, 1 division. Pressure: 2..12.
   always_comb begin
      op  = OP_MUL;
      opa = '0;
      opb = '0;
      b3_sum = ((32'(ac1 << 2)) + r2_ff) << oss;
      b3_pre = b3_sum + 32'd2;
      b4_t   = asr32(r0_ff + r1_ff + 32'd2, 5'd2) + 32'd32768;
      b7_diff = up - b3_ff;
      unique case (step_ff)
         5'd0:  begin opa = {16'd0, adc_ff[15:0]} - ac6; opb = ac5; end
         5'd1:  begin op = OP_SDIV; opa = mc << 11; opb = r0_ff + md; end
         5'd2:  begin opa = b6_ff; opb = b6_ff; end
         5'd3:  begin opa = b2; opb = r3_ff; end
         5'd4:  begin opa = ac2; opb = b6_ff; end
         5'd5:  begin opa = ac3; opb = b6_ff; end
         5'd6:  begin opa = b1; opb = r3_ff; end
         5'd7:  begin opa = ac4; opb = b4_t; end
         5'd8:  begin opa = b7_diff; opb = 32'd50000 >> oss; end
         5'd9:  begin
            op  = OP_UDIV;
            opa = r1_ff[31] ? r1_ff : r1_ff << 1;
            opb = r0_ff;
         end
         5'd10: begin opa = asr32(p_ff, 5'd8); opb = asr32(p_ff, 5'd8); end
         5'd11: begin opa = r0_ff; opb = 32'd3038; end
         5'd12: begin opa = 32'hFFFF_E343; opb = p_ff; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   assign last = cmd_ff ? (step_ff == 5'd12) : (step_ff == 5'd1);

   // Chain control and data path between unit operations.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd_in   = cmd_ff;
      adc_in   = adc_ff;
      term_in  = term_ff;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff; r3_in = r3_ff;
      b6_in = b6_ff; b3_in = b3_ff; p_in = p_ff;
      stat_in = stat_ff;
      val_in  = val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = command;
               adc_in   = adc_word;
               stat_in  = 1'b0;
               step_in  = command ? 5'd2 : 5'd0;
               b6_in    = term_ff - 32'd4000;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
            // Zero divisors skip the division.
            if (step_ff == 5'd1 && (r0_ff + md) == 32'd0) begin
               stat_in  = 1'b1;
               term_in  = r0_ff;
               val_in   = '0;
               state_in = ST_DONE;
            end else if (step_ff == 5'd9 && r0_ff == 32'd0) begin
               stat_in  = 1'b1;
               val_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_WAIT: begin
            if (alu_rsp.done) begin
               state_in = last ? ST_DONE : ST_ISSUE;
               step_in  = step_ff + 5'd1;
               unique case (step_ff)
                  5'd0:  r0_in = asr32(res, 5'd15);
                  5'd1:  begin
                     term_in = r0_ff + res;
                     val_in  = asr32(r0_ff + res + 32'd8, 5'd4);
                  end
                  5'd2:  r3_in = asr32(res, 5'd12);
                  5'd3:  r2_in = asr32(res, 5'd11);
                  5'd4:  begin
                     r2_in = r2_ff + asr32(res, 5'd11);
                  end
                  5'd5:  begin
                     r0_in = asr32(res, 5'd13);
                     b3_in = 32'($signed(b3_pre) / 32'sd4);
                  end
                  5'd6:  r1_in = asr32(res, 5'd16);
                  5'd7:  r0_in = res >> 15;
                  5'd8:  r1_in = res;
                  5'd9:  p_in = r1_ff[31] ? res << 1 : res;
                  5'd10: r0_in = res;
                  5'd11: r1_in = asr32(res, 5'd16);
                  5'd12: val_in = p_ff + asr32(r1_ff + asr32(res, 5'd16) + 32'd3791, 5'd4);
                  default: r3_in = r3_ff;
               endcase
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         term_ff  <= term_in;
      end
      cmd_ff  <= cmd_in;
      adc_ff  <= adc_in;
      r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in; r3_ff <= r3_in;
      b6_ff <= b6_in; b3_ff <= b3_in; p_ff <= p_in;
      stat_ff <= stat_in;
      val_ff  <= val_in;
   end

   assign alu_req.start = (state_ff == ST_ISSUE) && (state_in == ST_WAIT);
   assign alu_req.op    = op;
   assign alu_req.a     = opa;
   assign alu_req.b     = opb;
   assign finish = (state_ff == ST_DONE);
   assign kind   = cmd_ff;
   assign value  = val_ff;
   assign status = stat_ff;

endmodule
`default_nettype wire
